FILE: rtl/gcd_pkg.sv
// Shared constants, the arctangent table and angle reduction for the
// great-circle distance pipeline. No dependencies.
`default_nettype none

package gcd_pkg;

	localparam int TRIG_ITERATIONS = 24;
	localparam int SQRT_STEPS      = 31;
	localparam int LATENCY         = 2 * TRIG_ITERATIONS + 49;

	localparam int ANG_W  = 33;
	localparam int MAG_W  = 29;
	localparam int XY_W   = 34;
	localparam int Z_W    = 33;
	localparam int TRIG_W = 32;
	localparam int RAD_W  = 24;
	localparam int DIST_W = 19;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd6371009;

	localparam logic signed [ANG_W-1:0] UNIT_QUARTER = 33'sd377487360;
	localparam logic signed [ANG_W-1:0] UNIT_HALF    = 33'sd754974720;
	localparam logic signed [ANG_W-1:0] UNIT_FULL    = 33'sd1509949440;

	localparam logic [31:0]             PI_Q30      = 32'd3373259426;
	localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 33'sd1686629713;
	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0]      ONE_Q30     = 32'sd1073741824;
	localparam logic signed [31:0]      NEG_ONE_Q30 = -32'sd1073741824;

	// floor(PI_Q30 * 2^29 / (180 * 2^22))
	localparam logic [31:0] RAD_RECIP = 32'd2398762258;
	localparam logic [60:0] DEG_DIV   = 61'd754974720;
	localparam logic [60:0] DEG_HALF  = 61'd377487360;

	// floor(2^30 / 25)
	localparam logic [25:0] DIV25_RECIP = 26'd42949672;
	localparam logic [DIST_W-1:0] DIST_MAX = 19'd524287;

	localparam logic signed [Z_W-1:0] ATAN_Q30 [32] = '{
		33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
		33'sd67021686, 33'sd33543515, 33'sd16775850, 33'sd8388437,
		33'sd4194282, 33'sd2097149, 33'sd1048575, 33'sd524287,
		33'sd262143, 33'sd131071, 33'sd65535, 33'sd32767,
		33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
		33'sd1023, 33'sd511, 33'sd255, 33'sd127,
		33'sd63, 33'sd31, 33'sd15, 33'sd7,
		33'sd3, 33'sd1, 33'sd0, 33'sd0
	};

	// wrap into [-180, 180) degrees; input lies within (-360, 720) degrees
	function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] w;
		w = a;
		if (w < 0)
			w = w + UNIT_FULL;
		if (w >= UNIT_FULL)
			w = w - UNIT_FULL;
		if (w >= UNIT_HALF)
			w = w - UNIT_FULL;
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gcd_sincos.sv
// Pipelined sine and cosine: angle reduction, conversion to Q30 radians
// and one rotation CORDIC step per stage. Depends on gcd_pkg.
`default_nettype none

module gcd_sincos (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	input  logic signed [gcd_pkg::ANG_W-1:0]      ang,
	output logic                                  trig_valid,
	output logic signed [gcd_pkg::TRIG_W-1:0]     sine,
	output logic signed [gcd_pkg::TRIG_W-1:0]     cosine
);

	localparam int N = gcd_pkg::TRIG_ITERATIONS;

	logic                               v_s1, v_s2, v_s3, v_out_s;
	logic signed [gcd_pkg::ANG_W-1:0]   a_s1;
	logic                               neg_s2, flip_s2, neg_s3, flip_s3;
	logic [gcd_pkg::MAG_W-1:0]          mag_s2;
	logic [60:0]                        num_s3;
	logic [31:0]                        q0_s3;

	logic                               v_s [N+1];
	logic                               f_s [N+1];
	logic signed [gcd_pkg::XY_W-1:0]    x_s [N+1];
	logic signed [gcd_pkg::XY_W-1:0]    y_s [N+1];
	logic signed [gcd_pkg::Z_W-1:0]     z_s [N+1];

	logic signed [gcd_pkg::ANG_W-1:0]   fold;
	logic                               fold_flip;
	logic [60:0]                        est;
	logic [61:0]                        qd;
	logic [31:0]                        zmag;

	always_comb begin
		fold      = a_s1;
		fold_flip = 1'b0;
		if (a_s1 > gcd_pkg::UNIT_QUARTER) begin
			fold      = a_s1 - gcd_pkg::UNIT_HALF;
			fold_flip = 1'b1;
		end else if (a_s1 < -gcd_pkg::UNIT_QUARTER) begin
			fold      = a_s1 + gcd_pkg::UNIT_HALF;
			fold_flip = 1'b1;
		end
	end

	assign est  = 61'(mag_s2) * 61'(gcd_pkg::RAD_RECIP) + 61'(32'd536870912);
	assign qd   = 62'(q0_s3) * 62'(gcd_pkg::DEG_DIV);
	assign zmag = (62'(num_s3) < qd) ? q0_s3 - 32'd1 : q0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_s1   <= req_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= gcd_pkg::wrap_angle(ang);
		neg_s2  <= fold[gcd_pkg::ANG_W-1];
		flip_s2 <= fold_flip;
		mag_s2  <= gcd_pkg::MAG_W'(fold[gcd_pkg::ANG_W-1] ? -fold : fold);
		neg_s3  <= neg_s2;
		flip_s3 <= flip_s2;
		num_s3  <= 61'(mag_s2) * 61'(gcd_pkg::PI_Q30) + gcd_pkg::DEG_HALF;
		q0_s3   <= est[60:29];
		f_s[0]  <= flip_s3;
		x_s[0]  <= gcd_pkg::CORDIC_GAIN;
		y_s[0]  <= '0;
		z_s[0]  <= neg_s3 ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - gcd_pkg::ATAN_Q30[i];
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + gcd_pkg::ATAN_Q30[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out_s <= 1'b0;
		else
			v_out_s <= v_s[N];
	end

	always_ff @(posedge clk) begin
		sine   <= gcd_pkg::TRIG_W'(f_s[N] ? -y_s[N] : y_s[N]);
		cosine <= gcd_pkg::TRIG_W'(f_s[N] ? -x_s[N] : x_s[N]);
	end

	assign trig_valid = v_out_s;

endmodule

`default_nettype wire

FILE: rtl/great_circle_distance.sv
// Great-circle distance by the spherical law of cosines, fully pipelined.
// Depends on gcd_pkg and gcd_sincos.
//
//   channel   signals                                        handshake
//   request   start, busy, first_lat/lon, second_lat/lon     start & !busy
//   result    done, distance_tenths_km                       one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_data                 valid & ready
//
// One request per cycle; busy stays low.
// Each result passes through two CORDIC chains in series and the
// 31-stage square root.
// Reset clears all valid bits and loads the default radius.
// The receiver cannot stall; the pipeline always advances.
`default_nettype none

module great_circle_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [29:0]                  first_lat,
	input  logic signed [30:0]                  first_lon,
	input  logic signed [29:0]                  second_lat,
	input  logic signed [30:0]                  second_lon,
	output logic                                done,
	output logic [gcd_pkg::DIST_W-1:0]          distance_tenths_km,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gcd_pkg::RAD_W-1:0]           cfg_data
);

	localparam int N  = gcd_pkg::TRIG_ITERATIONS;
	localparam int NS = gcd_pkg::SQRT_STEPS;

	logic [gcd_pkg::RAD_W-1:0] radius_q;

	logic                            v_s1, v_s2;
	logic signed [29:0]              lat1_s1, lat2_s1;
	logic signed [30:0]              lon1_s1, lon2_s1;
	logic signed [gcd_pkg::ANG_W-1:0] lat1_s2, lat2_s2, dlon_s2;
	logic signed [31:0]              diff;

	logic                            tv1, tv2, tv3;
	logic signed [31:0]              s1, c1, s2, c2, sd, cd;

	logic                            v_p1, v_p2, v_p3;
	logic signed [63:0]              ss_p1, cc_p1, ss_p2, pr_p2;
	logic signed [31:0]              cd_p1, cv_p3;
	logic signed [33:0]              cc_sh;
	logic signed [63:0]              sum;
	logic signed [33:0]              cval;

	logic                            v_q1, v_q2;
	logic [61:0]                     csq_q1;
	logic signed [31:0]              c_q1, c_q2;
	logic [61:0]                     rem_q2;

	logic                            sq_v_s [NS+1];
	logic [61:0]                     sq_x_s [NS+1];
	logic [61:0]                     sq_r_s [NS+1];
	logic signed [31:0]              sq_c_s [NS+1];

	logic                            vv_s [N+1];
	logic signed [gcd_pkg::XY_W-1:0] vx_s [N+1];
	logic signed [gcd_pkg::XY_W-1:0] vy_s [N+1];
	logic signed [gcd_pkg::Z_W-1:0]  va_s [N+1];

	logic                            v_m0, v_m1, v_m2, v_m3, v_m4;
	logic [31:0]                     ang_m0;
	logic [55:0]                     prod_m1;
	logic [24:0]                     m_m2, m_m3;
	logic [56:0]                     rsum;
	logic [50:0]                     qe;
	logic [20:0]                     q0_m3;
	logic [21:0]                     rem25;
	logic [21:0]                     qf;
	logic [gcd_pkg::DIST_W-1:0]      dist_m4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= gcd_pkg::RADIUS_RESET;
		else if (cfg_valid && cfg_ready)
			radius_q <= cfg_data;
	end

	// capture request, form |dlon|
	assign diff = 32'(lon1_s1) - 32'(lon2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		lat1_s1 <= first_lat;
		lon1_s1 <= first_lon;
		lat2_s1 <= second_lat;
		lon2_s1 <= second_lon;
		lat1_s2 <= gcd_pkg::ANG_W'(lat1_s1);
		lat2_s2 <= gcd_pkg::ANG_W'(lat2_s1);
		dlon_s2 <= $signed({1'b0, diff[31] ? -diff : diff});
	end

	gcd_sincos u_trig_lat1 (
		.clk, .arst_n, .req_valid(v_s2), .ang(lat1_s2),
		.trig_valid(tv1), .sine(s1), .cosine(c1)
	);

	gcd_sincos u_trig_lat2 (
		.clk, .arst_n, .req_valid(v_s2), .ang(lat2_s2),
		.trig_valid(tv2), .sine(s2), .cosine(c2)
	);

	gcd_sincos u_trig_dlon (
		.clk, .arst_n, .req_valid(v_s2), .ang(dlon_s2),
		.trig_valid(tv3), .sine(sd), .cosine(cd)
	);

	// cosine argument
	assign cc_sh = 34'(cc_p1 >>> 30);
	assign sum   = ss_p2 + pr_p2 + 64'sd536870912;
	assign cval  = 34'(sum >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_q1 <= 1'b0;
			v_q2 <= 1'b0;
		end else begin
			v_p1 <= tv1 && tv2 && tv3 && (sd == sd);
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_q1 <= v_p3;
			v_q2 <= v_q1;
		end
	end

	always_ff @(posedge clk) begin
		ss_p1 <= 64'(s1) * 64'(s2);
		cc_p1 <= 64'(c1) * 64'(c2);
		cd_p1 <= cd;
		ss_p2 <= ss_p1;
		pr_p2 <= 64'(cc_sh) * 64'(cd_p1);
		if (cval > 34'(gcd_pkg::ONE_Q30))
			cv_p3 <= gcd_pkg::ONE_Q30;
		else if (cval < 34'(gcd_pkg::NEG_ONE_Q30))
			cv_p3 <= gcd_pkg::NEG_ONE_Q30;
		else
			cv_p3 <= 32'(cval);
		csq_q1 <= 62'(64'(cv_p3) * 64'(cv_p3));
		c_q1   <= cv_p3;
		rem_q2 <= (62'd1 << 60) - csq_q1;
		c_q2   <= c_q1;
	end

	// square root, one result bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v_s[0] <= 1'b0;
		else
			sq_v_s[0] <= v_q2;
	end

	always_ff @(posedge clk) begin
		sq_x_s[0] <= rem_q2;
		sq_r_s[0] <= '0;
		sq_c_s[0] <= c_q2;
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (2 * (NS - 1 - j));
		logic [61:0] trial;
		assign trial = sq_r_s[j] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[j+1] <= 1'b0;
			else
				sq_v_s[j+1] <= sq_v_s[j];
		end

		always_ff @(posedge clk) begin
			sq_c_s[j+1] <= sq_c_s[j];
			if (sq_x_s[j] >= trial) begin
				sq_x_s[j+1] <= sq_x_s[j] - trial;
				sq_r_s[j+1] <= (sq_r_s[j] >> 1) + BIT;
			end else begin
				sq_x_s[j+1] <= sq_x_s[j];
				sq_r_s[j+1] <= sq_r_s[j] >> 1;
			end
		end
	end

	// arc cosine by vectoring CORDIC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vv_s[0] <= 1'b0;
		else
			vv_s[0] <= sq_v_s[NS];
	end

	always_ff @(posedge clk) begin
		if (sq_c_s[NS] < 0) begin
			vx_s[0] <= gcd_pkg::XY_W'(sq_r_s[NS]);
			vy_s[0] <= -gcd_pkg::XY_W'(sq_c_s[NS]);
			va_s[0] <= gcd_pkg::HALF_PI_Q30;
		end else begin
			vx_s[0] <= gcd_pkg::XY_W'(sq_c_s[NS]);
			vy_s[0] <= gcd_pkg::XY_W'(sq_r_s[NS]);
			va_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vv_s[i+1] <= 1'b0;
			else
				vv_s[i+1] <= vv_s[i];
		end

		always_ff @(posedge clk) begin
			if (vy_s[i] >= 0) begin
				vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
				va_s[i+1] <= va_s[i] + gcd_pkg::ATAN_Q30[i];
			end else begin
				vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
				va_s[i+1] <= va_s[i] - gcd_pkg::ATAN_Q30[i];
			end
		end
	end

	// scale by radius, round to tenths of a km
	assign rsum  = 57'(prod_m1) + (57'd50 << 30);
	assign qe    = 51'(m_m2) * 51'(gcd_pkg::DIV25_RECIP);
	assign rem25 = 22'(m_m3) - 22'(q0_m3) * 22'd25;
	assign qf    = (rem25 >= 22'd25) ? 22'(q0_m3) + 22'd1 : 22'(q0_m3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m0 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
		end else begin
			v_m0 <= vv_s[N];
			v_m1 <= v_m0;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (va_s[N] < 0)
			ang_m0 <= '0;
		else if (va_s[N] > $signed({1'b0, gcd_pkg::PI_Q30}))
			ang_m0 <= gcd_pkg::PI_Q30;
		else
			ang_m0 <= 32'(va_s[N]);
		prod_m1 <= 56'(ang_m0) * 56'(radius_q);
		m_m2    <= rsum[56:32];
		q0_m3   <= qe[50:30];
		m_m3    <= m_m2;
		dist_m4 <= (qf > 22'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : gcd_pkg::DIST_W'(qf);
	end

	assign done               = v_m4;
	assign distance_tenths_km = dist_m4;

endmodule

`default_nettype wire

FILE: rtl/gcd_checker.sv
// Port-level checks for great_circle_distance, attached by bind.
// Depends on gcd_pkg.
`default_nettype none

module gcd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         cfg_ready
);

	a_done_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, gcd_pkg::LATENCY + 1))
		else $error("result strobe without matching request");

	a_request_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(gcd_pkg::LATENCY + 1) done)
		else $error("request lost in pipeline");

	a_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block refused a request");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .cfg_ready(cfg_ready)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for great_circle_distance: drives random and directed
// point pairs, predicts each distance in fixed point and checks every result.
// Depends on gcd_pkg and the great_circle_distance RTL.
`default_nettype none

module tb_top;
	import gcd_pkg::*;

	typedef struct {
		logic signed [29:0] first_lat;
		logic signed [30:0] first_lon;
		logic signed [29:0] second_lat;
		logic signed [30:0] second_lon;
	} point_pair_t;

	localparam longint DEG_HALF_TURN = longint'(180) << 22;
	localparam longint DEG_FULL_TURN = longint'(360) << 22;
	localparam longint DEG_QUARTER   = longint'(90) << 22;
	localparam longint Q30_ONE       = longint'(1) << 30;
	localparam longint LAT_EDGE      = 377487360;
	localparam longint LON_EDGE      = 754974720;
	localparam int     STALL_LIMIT   = 5000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [29:0]   first_lat = '0;
	logic signed [30:0]   first_lon = '0;
	logic signed [29:0]   second_lat = '0;
	logic signed [30:0]   second_lon = '0;
	logic                 done;
	logic [DIST_W-1:0]    distance_tenths_km;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [RAD_W-1:0]     cfg_data = '0;

	point_pair_t          pair_q[$];
	logic [DIST_W-1:0]    distance_q[$];
	logic [RAD_W-1:0]     radius_m = RADIUS_RESET;
	int                   send_idle_pct = 0;
	bit                   hold_requests = 1'b0;
	bit                   taken = 1'b0;
	int                   n_requests = 0;
	int                   n_distances = 0;
	int                   n_errors = 0;
	int                   n_saturated = 0;
	int                   stall_cycles = 0;

	great_circle_distance dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.first_lat          (first_lat),
		.first_lon          (first_lon),
		.second_lat         (second_lat),
		.second_lon         (second_lon),
		.done               (done),
		.distance_tenths_km (distance_tenths_km),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic rotate_sin_cos(input longint a, output longint s, output longint c);
		bit flip;
		bit negz;
		longint z, x, y, dx, dy, mag;
		flip = 1'b0;
		a = a % DEG_FULL_TURN;
		if (a < 0)
			a += DEG_FULL_TURN;
		if (a >= DEG_HALF_TURN)
			a -= DEG_FULL_TURN;
		if (a > DEG_QUARTER) begin
			a -= DEG_HALF_TURN;
			flip = 1'b1;
		end else if (a < -DEG_QUARTER) begin
			a += DEG_HALF_TURN;
			flip = 1'b1;
		end
		negz = a < 0;
		mag = negz ? -a : a;
		z = (mag * longint'(PI_Q30) + DEG_HALF_TURN / 2) / DEG_HALF_TURN;
		if (negz)
			z = -z;
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < TRIG_ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint central_angle(input longint c);
		longint unsigned rem, root, bitv;
		longint x, y, ang, t, dx, dy;
		rem = (longint'(1) << 60) - c * c;
		root = 0;
		bitv = longint'(1) << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		x = c;
		y = longint'(root);
		ang = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			ang = longint'(HALF_PI_Q30);
		end
		for (int i = 0; i < TRIG_ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; ang += longint'(ATAN_Q30[i]);
			end else begin
				x -= dx; y += dy; ang -= longint'(ATAN_Q30[i]);
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > longint'(PI_Q30))
			ang = longint'(PI_Q30);
		return ang;
	endfunction

	task automatic predict_distance(input point_pair_t p, input logic [RAD_W-1:0] rad,
			output logic [DIST_W-1:0] dist_out);
		longint dlon, s1, c1, s2, c2, sd, cd, cc, cval;
		longint unsigned dist_val;
		dlon = longint'(p.first_lon) - longint'(p.second_lon);
		if (dlon < 0)
			dlon = -dlon;
		rotate_sin_cos(longint'(p.first_lat), s1, c1);
		rotate_sin_cos(longint'(p.second_lat), s2, c2);
		rotate_sin_cos(dlon, sd, cd);
		cc = (c1 * c2) >>> 30;
		cval = (s1 * s2 + cc * cd + (Q30_ONE >> 1)) >>> 30;
		if (cval > Q30_ONE)
			cval = Q30_ONE;
		if (cval < -Q30_ONE)
			cval = -Q30_ONE;
		dist_val = (longint'(central_angle(cval)) * longint'(rad) + (longint'(50) << 30))
			/ (longint'(100) << 30);
		if (dist_val >= longint'(DIST_MAX)) begin
			dist_val = longint'(DIST_MAX);
			n_saturated++;
		end
		dist_out = dist_val[DIST_W-1:0];
	endtask

	function automatic point_pair_t make_pair(input longint lat1, input longint lon1,
			input longint lat2, input longint lon2);
		point_pair_t p;
		p.first_lat = lat1[29:0];
		p.first_lon = lon1[30:0];
		p.second_lat = lat2[29:0];
		p.second_lon = lon2[30:0];
		return p;
	endfunction

	function automatic longint span(input longint edge_val);
		return longint'($urandom_range(32'(2 * edge_val))) - edge_val;
	endfunction

	function automatic point_pair_t random_pair();
		longint lat1, lon1, d;
		lat1 = span(LAT_EDGE);
		lon1 = span(LON_EDGE);
		d = longint'($urandom_range(4000000)) - 2000000;
		case ($urandom_range(9))
			0, 1: return make_pair($urandom, $urandom, $urandom, $urandom);
			2, 3: return make_pair(lat1, lon1, lat1 + d, lon1 - d);
			4: return make_pair(lat1, lon1, -lat1 + d, lon1 + LON_EDGE + d);
			5: return make_pair(lat1, lon1, lat1, lon1);
			default: return make_pair(lat1, lon1, span(LAT_EDGE), span(LON_EDGE));
		endcase
	endfunction

	// driver: advance to the next request once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			if (hold_requests || pair_q.size() == 0 ||
					$urandom_range(99) < send_idle_pct) begin
				start <= 1'b0;
			end else begin
				point_pair_t p;
				p = pair_q.pop_front();
				start <= 1'b1;
				first_lat <= p.first_lat;
				first_lon <= p.first_lon;
				second_lat <= p.second_lat;
				second_lon <= p.second_lon;
			end
		end
		taken = 1'b0;
	end

	// monitor: predict on each accepted request, check each result
	always @(posedge clk) begin
		if (arst_n) begin
			bit moved;
			moved = 1'b0;
			if (start && !busy) begin
				logic [DIST_W-1:0] want;
				predict_distance(make_pair(first_lat, first_lon, second_lat, second_lon),
					radius_m, want);
				distance_q.push_back(want);
				taken = 1'b1;
				n_requests++;
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				n_distances++;
				if (distance_q.size() == 0) begin
					$error("distance_tenths_km: unexpected result %0d", distance_tenths_km);
					n_errors++;
				end else begin
					logic [DIST_W-1:0] want;
					want = distance_q.pop_front();
					if (distance_tenths_km !== want) begin
						$error("distance_tenths_km: expected %0d, actual %0d",
							want, distance_tenths_km);
						n_errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pair_q.size() != 0 || start || distance_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_radius(input logic [RAD_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		radius_m = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [RAD_W-1:0] radii [5];
		int idle_pcts [5];
		radii = '{24'd16777215, 24'd1, RADIUS_RESET, 24'd0, 24'd0};
		idle_pcts = '{0, 70, 0, 36, 70};
		radii[3] = 24'($urandom_range(16777215, 1));
		radii[4] = 24'($urandom_range(9000000, 1000000));
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: poles, antipodes, date line, field extremes, wraparound
		pair_q.push_back(make_pair(0, 0, 0, 0));
		pair_q.push_back(make_pair(0, 0, 0, LON_EDGE));
		pair_q.push_back(make_pair(LAT_EDGE, 0, -LAT_EDGE, 0));
		pair_q.push_back(make_pair(LAT_EDGE, 12345, LAT_EDGE, -98765));
		pair_q.push_back(make_pair(0, LON_EDGE, 0, -LON_EDGE));
		pair_q.push_back(make_pair(0, -LON_EDGE, 0, LON_EDGE));
		pair_q.push_back(make_pair(-LAT_EDGE, LON_EDGE, LAT_EDGE, -LON_EDGE));
		pair_q.push_back(make_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1));
		pair_q.push_back(make_pair((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30)));
		pair_q.push_back(make_pair(-(1 << 29), (1 << 30) - 1, -(1 << 29), -(1 << 30)));
		pair_q.push_back(make_pair(LAT_EDGE / 2, LON_EDGE / 2, -LAT_EDGE / 2,
			-LON_EDGE / 2));
		pair_q.push_back(make_pair(0, 1, 0, 0));
		pair_q.push_back(make_pair(1, 0, -1, 0));
		pair_q.push_back(make_pair(200000000, 300000000, 200000000, 300000001));
		pair_q.push_back(make_pair(-LAT_EDGE, 0, -LAT_EDGE + 1, LON_EDGE));
		pair_q.push_back(make_pair(0, LON_EDGE - 1, 0, -LON_EDGE + 1));
		pair_q.push_back(make_pair(100000000, 0, -100000000, LON_EDGE));
		pair_q.push_back(make_pair(LAT_EDGE + 1, 0, -LAT_EDGE - 1, 0));
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			write_radius(radii[ph]);
			send_idle_pct = idle_pcts[ph];
			for (int k = 0; k < 340; k++)
				pair_q.push_back(random_pair());
			if (ph == 1) begin
				while (pair_q.size() > 170)
					@(posedge clk);
				hold_requests = 1'b1;
				while (start || distance_q.size() != 0)
					@(posedge clk);
				@(negedge clk);
				hold_requests = 1'b0;
			end
			wait_drained();
		end

		repeat (LATENCY + 20) @(posedge clk);
		$display("coverage: %0d requests, %0d distances, %0d saturated, 6 radius settings",
			n_requests, n_distances, n_saturated);
		if (n_errors == 0 && distance_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: great_circle_distance.f
rtl/gcd_pkg.sv
rtl/gcd_sincos.sv
rtl/great_circle_distance.sv
rtl/gcd_checker.sv
tb/sv/tb_top.sv
